// ----- hw/rtl/gdad_pkg.sv -----
package gdad_pkg;

    localparam int DAY_W          = 5;
    localparam int MONTH_W        = 4;
    localparam int YEAR_W         = 14;
    localparam int COUNT_BITS_DEF = 16;
    localparam int OUT_DATA_W     = 24;
    localparam int OUT_USER_W     = 2;

    localparam logic [YEAR_W-1:0]  TOP_YEAR = 14'd9999;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
    localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
    localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
    localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

    // floor(y / 100) = (y * 5243) >> 19, exact for y below 43699
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = 27;
    localparam int QUOT_W       = 8;
    localparam int MOD100_W     = 7;
    localparam logic [MOD100_W-1:0] MOD100_TOP = 7'd99;
    localparam logic [YEAR_W-1:0]   CENTURY    = 14'd100;

    localparam int USER_INVALID  = 0;
    localparam int USER_OVERFLOW = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_CHECK,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div;
        logic rem;
        logic adv;
    } cal_ctl_t;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [DAY_W-1:0]   mlen;
        logic               at_top;
    } cal_stat_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
            MON_FEB:                            len = leap ? LEN_29 : LEN_28;
            default:                            len = LEN_31;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/gregorian_date_add_days.sv -----
// Channel | Dir | Ports                      | Contents
// s_      | in  | s_tvalid s_tready s_tdata  | start date and day count
// m_      | out | m_tvalid m_tready m_tdata  | end date
//         |     | m_tuser                    | date_invalid, year_overflow
// Each word passes the load, divide, remainder and check states, then steps month by
// month in the single month-length subtract loop; a rejected date skips the loop.
// s_tready is high only in idle; a finished word sits in the output register
// while the next word is taken. m_tready low stalls only the final hand-off.
// Reset clears the sequencer and the output valid; no clearing pass.
module gregorian_date_add_days
    import gdad_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_day, start_month, start_year, add_count
    input  logic [((DAY_W+MONTH_W+YEAR_W+COUNT_BITS+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // end_day, end_month, end_year
    output logic [OUT_DATA_W-1:0] m_tdata,
    // date_invalid, year_overflow
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam int DN_W    = COUNT_BITS + 1;
    localparam int CNT_LSB = DAY_W + MONTH_W + YEAR_W;

    state_t                  state_reg, state_next;
    logic [DAY_W-1:0]        day_reg, day_next;
    logic [DN_W-1:0]         dn_reg, dn_next;
    logic                    inv_reg, inv_next;
    logic                    ovf_reg, ovf_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0]   out_user_reg, out_user_next;

    logic [DAY_W-1:0]        s_day;
    logic [MONTH_W-1:0]      s_month;
    logic [YEAR_W-1:0]       s_year;
    logic [COUNT_BITS-1:0]   s_count;

    cal_ctl_t                ctl;
    cal_stat_t               stat;
    logic                    more;
    logic [DN_W-1:0]         diff;
    logic                    bad_date;

    assign s_day   = s_tdata[DAY_W-1:0];
    assign s_month = s_tdata[DAY_W +: MONTH_W];
    assign s_year  = s_tdata[DAY_W+MONTH_W +: YEAR_W];
    assign s_count = s_tdata[CNT_LSB +: COUNT_BITS];

    gdad_cal u_cal (
        .aclk        (aclk),
        .start_month (s_month),
        .start_year  (s_year),
        .ctl         (ctl),
        .stat        (stat)
    );

    gdad_alu #(
        .DN_W (DN_W)
    ) u_alu (
        .dn   (dn_reg),
        .len  (stat.mlen),
        .more (more),
        .diff (diff)
    );

    assign bad_date = (stat.month < MON_JAN) || (stat.month > MON_DEC) ||
                      (stat.year > TOP_YEAR) || (day_reg == '0) ||
                      (day_reg > stat.mlen);

    always_comb begin
        state_next     = state_reg;
        day_next       = day_reg;
        dn_next        = dn_reg;
        inv_next       = inv_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        ctl            = '0;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    day_next   = s_day;
                    dn_next    = DN_W'(s_day) + DN_W'(s_count);
                    ctl.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                ctl.div    = 1'b1;
                state_next = ST_REM;
            end
            ST_REM: begin
                ctl.rem    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                inv_next   = bad_date;
                ovf_next   = 1'b0;
                state_next = bad_date ? ST_DONE : ST_STEP;
            end
            ST_STEP: begin
                if (more) begin
                    dn_next = diff;
                    if ((stat.month == MON_DEC) && stat.at_top) begin
                        ovf_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        ctl.adv = 1'b1;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_user_next  = '0;
                    out_user_next[USER_INVALID]  = inv_reg;
                    out_user_next[USER_OVERFLOW] = ovf_reg && !inv_reg;
                    if (inv_reg) begin
                        out_data_next = '0;
                    end else if (ovf_reg) begin
                        out_data_next = {1'b0, TOP_YEAR, MON_DEC, LEN_31};
                    end else begin
                        out_data_next = {1'b0, stat.year, stat.month, dn_reg[DAY_W-1:0]};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        day_reg      <= day_next;
        dn_reg       <= dn_next;
        inv_reg      <= inv_next;
        ovf_reg      <= ovf_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[USER_INVALID]) |-> (m_tdata == '0))
        else $error("invalid date word carries nonzero fields");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[USER_INVALID] && m_tuser[USER_OVERFLOW]))
        else $error("invalid and overflow both set");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[USER_INVALID]) |->
        ((m_tdata[DAY_W-1:0] != '0) && (m_tdata[DAY_W +: MONTH_W] != '0) &&
         (m_tdata[DAY_W +: MONTH_W] <= MON_DEC)))
        else $error("result date out of range");

    a_month_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |->
        ((stat.month >= MON_JAN) && (stat.month <= MON_DEC)))
        else $error("month out of range while stepping");

    a_dn_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |=> (dn_reg <= $past(dn_reg)))
        else $error("remaining day count grew while stepping");

endmodule

// ----- hw/rtl/gdad_cal.sv -----
module gdad_cal
    import gdad_pkg::*;
(
    input  logic               aclk,
    input  logic [MONTH_W-1:0] start_month,
    input  logic [YEAR_W-1:0]  start_year,
    input  cal_ctl_t           ctl,
    output cal_stat_t          stat
);

    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [MOD100_W-1:0] mod100_reg, mod100_next;
    logic [1:0]          cent_reg, cent_next;
    logic [PROD_W-1:0]   prod;
    logic [YEAR_W-1:0]   hundreds;
    logic                leap;

    assign prod     = PROD_W'(year_reg) * PROD_W'(DIV100_MUL);
    assign hundreds = YEAR_W'(quot_reg) * CENTURY;
    assign leap     = (year_reg[1:0] == 2'd0) && ((mod100_reg != '0) || (cent_reg == 2'd0));

    always_comb begin
        month_next  = month_reg;
        year_next   = year_reg;
        quot_next   = quot_reg;
        mod100_next = mod100_reg;
        cent_next   = cent_reg;
        if (ctl.load) begin
            month_next = start_month;
            year_next  = start_year;
        end
        if (ctl.div) begin
            quot_next = prod[DIV100_SHIFT +: QUOT_W];
        end
        if (ctl.rem) begin
            mod100_next = MOD100_W'(year_reg - hundreds);
            cent_next   = quot_reg[1:0];
        end
        if (ctl.adv) begin
            if (month_reg == MON_DEC) begin
                month_next = MON_JAN;
                year_next  = year_reg + YEAR_W'(1);
                if (mod100_reg == MOD100_TOP) begin
                    mod100_next = '0;
                    cent_next   = cent_reg + 2'd1;
                end else begin
                    mod100_next = mod100_reg + MOD100_W'(1);
                end
            end else begin
                month_next = month_reg + MONTH_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        month_reg  <= month_next;
        year_reg   <= year_next;
        quot_reg   <= quot_next;
        mod100_reg <= mod100_next;
        cent_reg   <= cent_next;
    end

    assign stat.month  = month_reg;
    assign stat.year   = year_reg;
    assign stat.mlen   = month_len(month_reg, leap);
    assign stat.at_top = (year_reg == TOP_YEAR);

endmodule

// ----- hw/rtl/gdad_alu.sv -----
module gdad_alu
    import gdad_pkg::*;
#(
    parameter int DN_W = COUNT_BITS_DEF + 1
) (
    input  logic [DN_W-1:0]  dn,
    input  logic [DAY_W-1:0] len,
    output logic             more,
    output logic [DN_W-1:0]  diff
);

    logic [DN_W:0] sub;

    assign sub  = {1'b0, dn} - (DN_W+1)'(len);
    assign more = !sub[DN_W] && (sub[DN_W-1:0] != '0);
    assign diff = sub[DN_W-1:0];

endmodule
